[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[design/ipvtv_pkg.sv]
package ipvtv_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned OCTET_W = 8;
    localparam int unsigned DOTS_W = 2;
    localparam int unsigned PORT_W = 16;

    localparam logic [DOTS_W-1:0] MAX_DOTS = 2'd3;
    localparam logic [11:0] MAX_OCTET = 12'd255;
    localparam logic [19:0] PORT_LIMIT = 20'd65535;
    localparam logic [PORT_W-1:0] PORT_FLOOR = 16'd1;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic KIND_ADDR = 1'b0;
    localparam logic KIND_PORT = 1'b1;

    typedef struct packed {
        logic [OCTET_W-1:0] octet_value;
        logic [DOTS_W-1:0] dot_count;
        logic digit_seen;
        logic [PORT_W-1:0] port_value;
        logic in_port_phase;
        logic failed;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '0;

    // Result of one character: whether it ends a pair, and the verdict.
    typedef struct packed {
        logic emit;
        logic ok;
    } step_res_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

[design/ipv4_port_text_validator_unit.sv]
// Checks an IPv4 dotted-quad address text followed by a decimal port text, one character
// per beat, each string ended by a NUL; the port's NUL yields one valid_res beat (1 when
// four octets of at most 255 and a port from 1 to 65535 were seen) and the unit starts over.
// One character is taken every cycle when the output is drained; out_valid is registered
// and rises after the terminating character, held in the input register, fires while the
// output slot is free. The rate is set by the update of the parse state register
// (multiply by ten, add, compare), and stalls on out_ready back up through the input register.
`include "assert_macros.svh"

module ipv4_port_text_validator_unit
    import ipvtv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [CHAR_W-1:0] text_char,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              valid_res
);

    logic              held_valid;
    logic              held_kind;
    logic [CHAR_W-1:0] held_char;
    logic              slot_free;
    logic              fire;
    step_res_t         res;

    assign fire = held_valid && slot_free;

    ipvtv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .text_char  (text_char),
        .take       (fire),
        .held_valid (held_valid),
        .held_kind  (held_kind),
        .held_char  (held_char)
    );

    ipvtv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (held_kind),
        .text_char (held_char),
        .res       (res)
    );

    ipvtv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

    `ASSERT_CLK(a_stall_holds_input, clk, rst_n, held_valid && !fire |=> held_valid && $stable(held_char))

endmodule

[design/ipvtv_in_stage.sv]
`include "assert_macros.svh"

module ipvtv_in_stage
    import ipvtv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [CHAR_W-1:0] text_char,
    input  logic              take,
    output logic              held_valid,
    output logic              held_kind,
    output logic [CHAR_W-1:0] held_char
);

    logic              valid_reg;
    logic              valid_next;
    logic              kind_reg;
    logic [CHAR_W-1:0] char_reg;

    // The held beat can be replaced in the same cycle it is consumed.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            char_reg <= text_char;
        end
    end

    assign held_valid = valid_reg;
    assign held_kind = kind_reg;
    assign held_char = char_reg;

    `ASSERT_NEVER(a_take_without_beat, clk, rst_n, take && !valid_reg)

endmodule

[design/ipvtv_core.sv]
`include "assert_macros.svh"

module ipvtv_core
    import ipvtv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              kind,
    input  logic [CHAR_W-1:0] text_char,
    output step_res_t         res
);

    parse_state_t state_reg;
    parse_state_t state_next;

    always_comb
    begin
        parse_state_t s;
        step_res_t    r;
        logic [11:0]  octet_sum;
        logic [19:0]  port_sum;
        logic [3:0]   digit;

        s = state_reg;
        r = '0;
        digit = text_char[3:0] - CHAR_ZERO[3:0];
        octet_sum = {1'b0, s.octet_value, 3'b000} + {3'b000, s.octet_value, 1'b0}
                    + {8'd0, digit};
        port_sum = {1'b0, s.port_value, 3'b000} + {3'b000, s.port_value, 1'b0}
                   + {16'd0, digit};

        if (kind == KIND_ADDR)
        begin
            if (s.in_port_phase)
            begin
                s.failed = 1'b1;
            end
            else if (text_char == CHAR_NUL)
            begin
                if (!(s.dot_count == MAX_DOTS && s.digit_seen))
                begin
                    s.failed = 1'b1;
                end
                s.in_port_phase = 1'b1;
                s.port_value = '0;
            end
            else if (!s.failed)
            begin
                if (is_digit(text_char))
                begin
                    if (octet_sum > MAX_OCTET)
                    begin
                        s.failed = 1'b1;
                    end
                    else
                    begin
                        s.octet_value = octet_sum[OCTET_W-1:0];
                        s.digit_seen = 1'b1;
                    end
                end
                else if (text_char == CHAR_DOT)
                begin
                    if (!s.digit_seen || s.dot_count == MAX_DOTS)
                    begin
                        s.failed = 1'b1;
                    end
                    else
                    begin
                        s.dot_count = s.dot_count + 2'd1;
                        s.digit_seen = 1'b0;
                        s.octet_value = '0;
                    end
                end
                else
                begin
                    s.failed = 1'b1;
                end
            end
        end
        else
        begin
            // A port beat during the address marks the pair bad and starts the port.
            if (!s.in_port_phase)
            begin
                s.failed = 1'b1;
                s.in_port_phase = 1'b1;
                s.port_value = '0;
            end
            if (text_char == CHAR_NUL)
            begin
                r.emit = 1'b1;
                r.ok = !s.failed && (s.port_value >= PORT_FLOOR);
                s = STATE_RESET;
            end
            else if (!s.failed)
            begin
                if (is_digit(text_char) && (port_sum <= PORT_LIMIT))
                begin
                    s.port_value = port_sum[PORT_W-1:0];
                end
                else
                begin
                    s.failed = 1'b1;
                end
            end
        end

        state_next = fire ? s : state_reg;
        res = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_CLK(a_reset_after_pair, clk, rst_n, fire && res.emit |=> state_reg == STATE_RESET)
    `ASSERT_CLK(a_port_idle_in_addr, clk, rst_n, !state_reg.in_port_phase |-> state_reg.port_value == '0)
    `ASSERT_CLK(a_empty_octet_zero, clk, rst_n, !state_reg.digit_seen |-> state_reg.octet_value == '0)

endmodule

[design/ipvtv_out_stage.sv]
`include "assert_macros.svh"

module ipvtv_out_stage
    import ipvtv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  step_res_t  res,
    output logic       slot_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res
);

    logic out_valid_reg;
    logic out_valid_next;
    logic valid_res_reg;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire && res.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
        begin
            valid_res_reg <= res.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, fire && res.emit && out_valid_reg && !out_ready)

endmodule

[tb/sv/ipv4_port_text_validator_unit_tb.sv]
`timescale 1ns / 1ps

module ipv4_port_text_validator_unit_tb;
    import ipvtv_pkg::*;

    localparam int unsigned RADIX = 10;
    localparam int unsigned REPORT_CAP = 20;

    typedef struct packed {
        logic              k;
        logic [CHAR_W-1:0] c;
    } char_beat_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_ADDR;
    logic [CHAR_W-1:0] text_char = CHAR_NUL;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              valid_res;

    // Shadow of the parser state, updated on every accepted character beat.
    logic [OCTET_W-1:0] exp_octet;
    logic [DOTS_W-1:0]  exp_dots;
    logic               exp_digit;
    logic [PORT_W-1:0]  exp_port;
    logic               exp_port_phase;
    logic               exp_failed;

    logic        verdict_q[$];
    char_beat_t  beat_q[$];

    int unsigned chars_sent = 0;
    int unsigned verdicts_ok = 0;
    int unsigned verdicts_bad = 0;
    int unsigned mismatches = 0;
    int unsigned holdoff_req = 0;
    int unsigned holdoff_done = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    ipv4_port_text_validator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .text_char (text_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("ipv4_port_text_validator_unit verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic clear_prediction();
        exp_octet      = '0;
        exp_dots       = '0;
        exp_digit      = 1'b0;
        exp_port       = '0;
        exp_port_phase = 1'b0;
        exp_failed     = 1'b0;
    endtask

    task automatic predict_char(input logic k, input logic [CHAR_W-1:0] c);
        int unsigned acc;
        logic        digit;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (k == KIND_ADDR)
        begin
            if (exp_port_phase)
            begin
                exp_failed = 1'b1;
            end
            else if (c == CHAR_NUL)
            begin
                if (!(exp_dots == MAX_DOTS && exp_digit))
                    exp_failed = 1'b1;
                exp_port_phase = 1'b1;
                exp_port       = '0;
            end
            else if (!exp_failed)
            begin
                if (digit)
                begin
                    acc = exp_octet * RADIX + (c - CHAR_ZERO);
                    if (acc > MAX_OCTET)
                    begin
                        exp_failed = 1'b1;
                    end
                    else
                    begin
                        exp_octet = acc[OCTET_W-1:0];
                        exp_digit = 1'b1;
                    end
                end
                else if (c == CHAR_DOT)
                begin
                    if (!exp_digit || exp_dots == MAX_DOTS)
                    begin
                        exp_failed = 1'b1;
                    end
                    else
                    begin
                        exp_dots  = exp_dots + 1'b1;
                        exp_digit = 1'b0;
                        exp_octet = '0;
                    end
                end
                else
                begin
                    exp_failed = 1'b1;
                end
            end
        end
        else
        begin
            // A port character while the address is still open fails the pair.
            if (!exp_port_phase)
            begin
                exp_failed     = 1'b1;
                exp_port_phase = 1'b1;
                exp_port       = '0;
            end
            if (c == CHAR_NUL)
            begin
                verdict_q.push_back(!exp_failed && exp_port >= PORT_FLOOR);
                clear_prediction();
            end
            else if (!exp_failed)
            begin
                if (digit)
                begin
                    acc = exp_port * RADIX + (c - CHAR_ZERO);
                    if (acc > PORT_LIMIT)
                        exp_failed = 1'b1;
                    else
                        exp_port = acc[PORT_W-1:0];
                end
                else
                begin
                    exp_failed = 1'b1;
                end
            end
        end
    endtask

    // Mostly back to back, sometimes a short gap, now and then a long gap.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    task automatic send_char(input logic k, input logic [CHAR_W-1:0] c);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        text_char <= c;
        do @(posedge clk); while (!in_ready);
        predict_char(k, c);
        chars_sent++;
    endtask

    task automatic append_text(input logic k, input string s);
        for (int i = 0; i < s.len(); i++)
            beat_q.push_back('{k, s[i]});
        beat_q.push_back('{k, CHAR_NUL});
    endtask

    task automatic send_beats();
        char_beat_t b;
        while (beat_q.size() != 0)
        begin
            b = beat_q.pop_front();
            send_char(b.k, b.c);
        end
    endtask

    task automatic send_pair(input string addr, input string port);
        append_text(KIND_ADDR, addr);
        append_text(KIND_PORT, port);
        send_beats();
    endtask

    function automatic string octet_text();
        int unsigned r;
        int unsigned v;
        string       s;
        r = $urandom_range(0, 19);
        if (r == 0)
            v = $urandom_range(256, 999);
        else if (r < 3)
            v = 0;
        else if (r < 5)
            v = 255;
        else if (r < 10)
            v = $urandom_range(0, 9);
        else
            v = $urandom_range(0, 255);
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        return s;
    endfunction

    function automatic string address_text();
        int unsigned n;
        string       s;
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 6) : 4;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                s = {s, "."};
            if ($urandom_range(0, 29) != 0)
                s = {s, octet_text()};
        end
        return s;
    endfunction

    function automatic string port_text();
        int unsigned r;
        string       s;
        r = $urandom_range(0, 19);
        case (r)
            0: s = "";
            1: s = ($urandom_range(0, 1) == 0) ? "0" : "00";
            2: s = $sformatf("%0d", $urandom_range(65536, 99999));
            3: s = "65535";
            4: s = "1";
            5: s = $sformatf("%0d0", $urandom_range(6554, 9999));
            default:
                s = $sformatf("%0d", $urandom_range(1, (r < 12) ? 999 : 65535));
        endcase
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        return s;
    endfunction

    task automatic send_random_pair();
        int unsigned pos;
        append_text(KIND_ADDR, address_text());
        append_text(KIND_PORT, port_text());
        // Now and then the pair is corrupted by a stray byte, a wrong kind or an extra beat.
        if ($urandom_range(0, 5) == 0)
        begin
            pos = $urandom_range(0, beat_q.size() - 1);
            case ($urandom_range(0, 2))
                0: beat_q[pos].c = CHAR_W'($urandom_range(1, 255));
                1: beat_q[pos].k = ~beat_q[pos].k;
                default:
                    beat_q.insert(pos, '{1'($urandom_range(0, 1)),
                                         CHAR_W'($urandom_range(0, 255))});
            endcase
        end
        send_beats();
    endtask

    task automatic test_extremes();
        send_pair("255.0.0.9", "65535");
    endtask

    task automatic test_special_cases();
        // Port terminator while the address is still open.
        send_char(KIND_PORT, CHAR_NUL);
        // Octet over range followed by a zero port.
        send_pair("256", "0");
        // Empty octet, early terminator, then an address character during the port.
        send_char(KIND_ADDR, CHAR_DOT);
        send_char(KIND_ADDR, CHAR_NUL);
        send_char(KIND_ADDR, CHAR_DOT);
        append_text(KIND_PORT, "65536");
        send_beats();
    endtask

    task automatic test_random_pairs(input int unsigned upto);
        while (chars_sent < upto)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            send_random_pair();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_holdoff();
        tx_steady   = 1'b1;
        holdoff_req = 300;
        for (int i = 0; i < 3; i++)
        begin
            send_pair("10.0.0.1", "80");
            repeat (6) send_char(KIND_PORT, CHAR_NUL);
        end
        repeat (4) send_char(KIND_PORT, CHAR_NUL);
        tx_steady = 1'b0;
    endtask

    task automatic test_random_noise(input int unsigned upto);
        int unsigned r;
        logic [CHAR_W-1:0] c;
        while (chars_sent < upto)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                c = CHAR_NUL;
            else if (r < 40)
                c = CHAR_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
            else if (r < 50)
                c = CHAR_DOT;
            else
                c = CHAR_W'($urandom_range(0, 255));
            send_char(1'($urandom_range(0, 1)), c);
        end
    endtask

    // Result side: checks each accepted beat and drives out_ready.
    initial
    begin : verdict_monitor
        int unsigned stall;
        logic        want;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected verdict %0b", valid_res));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (valid_res !== want)
                        report_mismatch($sformatf("valid_res %0b, expected %0b",
                                                  valid_res, want));
                    if (want)
                        verdicts_ok++;
                    else
                        verdicts_bad++;
                end
            end
            if (holdoff_req != 0)
            begin
                stall        = holdoff_req;
                holdoff_done = holdoff_req;
                holdoff_req  = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = rx_steady ? 0 : idle_len();
            end
        end
    end

    initial
    begin : main_sequence
        int unsigned waited;
        clear_prediction();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_special_cases();
        test_random_pairs(1440);
        test_output_holdoff();
        test_random_noise(1650);

        in_valid <= 1'b0;
        waited = 0;
        while (verdict_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

        $display("Run: %0d characters sent, %0d verdicts checked (%0d valid, %0d rejected).",
                 chars_sent, verdicts_ok + verdicts_bad, verdicts_ok, verdicts_bad);
        $display("Output held off for %0d cycles once; %0d mismatches.",
                 holdoff_done, mismatches);
        if (mismatches == 0)
            $display("ipv4_port_text_validator_unit verification clean");
        else
            $display("ipv4_port_text_validator_unit verification failed");
        $finish;
    end

endmodule
